@@ sv/bech32_string_encoder_assert.svh @@
// Assertion macros shared by the Bech32 string encoder RTL.
`ifndef BECH32_STRING_ENCODER_ASSERT_SVH
`define BECH32_STRING_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B32E_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bech32 encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define B32E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bech32 encoder check failed");

`endif

@@ sv/b32e_pkg.sv @@
// Shared types, constants and functions of the Bech32 string encoder.
package b32e_pkg;

  localparam int MAX_PREFIX = 128;
  localparam int LEN_W      = $clog2(MAX_PREFIX + 1);
  localparam int ADDR_W     = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;

  localparam logic [29:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [6:0] CHAR_SEP  = 7'h31;
  localparam logic [6:0] CHAR_NONE = 7'h00;

  typedef enum logic [1:0] {
    CMD_PREFIX = 2'd0,
    CMD_SEP    = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OSEL_PC,
    OSEL_ERR,
    OSEL_SEP,
    OSEL_DATA,
    OSEL_CHK
  } osel_t;

  typedef enum logic [1:0] {
    FSEL_TOP,
    FSEL_ZERO,
    FSEL_DATA
  } fsel_t;

  typedef struct packed {
    logic  ld_item;
    logic  start;
    logic  fold_en;
    fsel_t fold_sel;
    logic  x1;
    logic  store_en;
    logic  walk_clr;
    logic  walk_en;
    logic  emit;
    osel_t osel;
    logic  fin;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic len_full;
    logic dv_bad;
    logic walk_done;
    logic out_free;
  } ctrl_st_t;

  function automatic logic [29:0] fold(input logic [29:0] acc, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], v};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ GEN[i];
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] sym(input logic [4:0] idx);
    logic [7:0] ch;
    ch = CHARSET[8 * (31 - int'(idx)) +: 8];
    return ch[6:0];
  endfunction

endpackage

@@ sv/b32e_ctrl.sv @@
// Controller state machine that sequences each transfer of the Bech32 encoder.
module b32e_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  b32e_pkg::ctrl_st_t    st,
  output b32e_pkg::ctrl_cmd_t   cmd,
  output logic                  in_stall
);
  import b32e_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SEP,
    S_FOLD,
    S_CHK
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_DATA
  } phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] k_r, k_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.fold_sel = FSEL_ZERO;
    cmd.osel  = OSEL_PC;
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.cmd)
          CMD_PREFIX: begin
            if (st.out_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
              if ((phase_r == PH_PREFIX) && st.len_full) begin
                cmd.osel  = OSEL_ERR;
                phase_nxt = PH_IDLE;
              end else begin
                cmd.start    = (phase_r != PH_PREFIX);
                cmd.store_en = 1'b1;
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = FSEL_TOP;
                cmd.osel     = OSEL_PC;
                phase_nxt    = PH_PREFIX;
              end
            end
          end
          CMD_SEP: begin
            if (phase_r == PH_DATA) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.start    = (phase_r == PH_IDLE);
              cmd.fold_en  = 1'b1;
              cmd.fold_sel = FSEL_ZERO;
              cmd.walk_clr = 1'b1;
              state_nxt    = S_WALK;
            end
          end
          CMD_DATA: begin
            if (phase_r != PH_DATA) begin
              state_nxt = S_IDLE;
            end else if (st.out_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
              if (st.dv_bad) begin
                cmd.osel  = OSEL_ERR;
                phase_nxt = PH_IDLE;
              end else begin
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = FSEL_DATA;
                cmd.osel     = OSEL_DATA;
              end
            end
          end
          default: begin
            if (phase_r != PH_DATA) begin
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = 3'd0;
              state_nxt = S_FOLD;
            end
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (st.walk_done) begin
          state_nxt = S_SEP;
        end
      end
      S_SEP: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.osel  = OSEL_SEP;
          phase_nxt = PH_DATA;
          state_nxt = S_IDLE;
        end
      end
      S_FOLD: begin
        cmd.fold_en  = 1'b1;
        cmd.fold_sel = FSEL_ZERO;
        cmd.x1       = (k_r == 3'd5);
        k_nxt        = k_r + 3'd1;
        if (k_r == 3'd5) begin
          k_nxt     = 3'd0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.osel = OSEL_CHK;
          cmd.fin  = (k_r == 3'd5);
          k_nxt    = k_r + 3'd1;
          if (k_r == 3'd5) begin
            phase_nxt = PH_IDLE;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      k_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

@@ sv/b32e_dp.sv @@
// Datapath of the Bech32 encoder: polymod accumulator, prefix memory and output register.
module b32e_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b32e_pkg::ctrl_cmd_t  cmd,
  output b32e_pkg::ctrl_st_t   st,
  input  logic [1:0]           in_cmd,
  input  logic [6:0]           in_prefix_char,
  input  logic [7:0]           in_data_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           out_char,
  output logic                 out_last,
  output logic                 out_done_res,
  output logic                 out_error
);
  import b32e_pkg::*;

  logic [6:0]        mem [MAX_PREFIX];

  cmd_t              cmd_r;
  logic [6:0]        pc_r;
  logic [7:0]        dv_r;
  logic [29:0]       acc_r, acc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [6:0]        rd_data_r;
  logic              rd_go;
  logic [29:0]       fold_base;
  logic [4:0]        fold_v;
  logic              out_valid_r;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_err_r, out_err_nxt;

  assign len_eff = cmd.start ? '0 : len_r;
  assign rd_go   = cmd.walk_en && (cnt_r != len_r);

  assign st.cmd       = cmd_r;
  assign st.len_full  = (len_r == LEN_W'(MAX_PREFIX));
  assign st.dv_bad    = |dv_r[7:5];
  assign st.walk_done = (cnt_r == len_r) && !rd_vld_r;
  assign st.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    fold_base = cmd.start ? 30'd1 : acc_r;
    case (cmd.fold_sel)
      FSEL_TOP:  fold_v = {3'b000, pc_r[6:5]};
      FSEL_DATA: fold_v = dv_r[4:0];
      default:   fold_v = 5'd0;
    endcase

    acc_nxt = acc_r;
    if (cmd.fold_en) begin
      acc_nxt = fold(fold_base, fold_v) ^ {29'd0, cmd.x1};
    end else if (rd_vld_r) begin
      acc_nxt = fold(acc_r, rd_data_r[4:0]);
    end else if (cmd.emit && (cmd.osel == OSEL_CHK)) begin
      acc_nxt = {acc_r[24:0], 5'd0};
    end

    len_nxt = len_r;
    if (cmd.store_en) begin
      len_nxt = len_eff + LEN_W'(1);
    end else if (cmd.start) begin
      len_nxt = '0;
    end

    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    if (cmd.walk_clr) begin
      cnt_nxt = '0;
    end else if (rd_go) begin
      cnt_nxt    = cnt_r + LEN_W'(1);
      rd_vld_nxt = 1'b1;
    end

    out_char_nxt = pc_r;
    out_last_nxt = 1'b1;
    out_done_nxt = 1'b0;
    out_err_nxt  = 1'b0;
    case (cmd.osel)
      OSEL_ERR: begin
        out_char_nxt = CHAR_NONE;
        out_done_nxt = 1'b1;
        out_err_nxt  = 1'b1;
      end
      OSEL_SEP:  out_char_nxt = CHAR_SEP;
      OSEL_DATA: out_char_nxt = sym(dv_r[4:0]);
      OSEL_CHK: begin
        out_char_nxt = sym(acc_r[29:25]);
        out_last_nxt = cmd.fin;
        out_done_nxt = cmd.fin;
      end
      default:   out_char_nxt = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store_en) begin
      mem[len_eff[ADDR_W-1:0]] <= pc_r;
    end
    if (rd_go) begin
      rd_data_r <= mem[cnt_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      cmd_r <= cmd_t'(in_cmd);
      pc_r  <= in_prefix_char;
      dv_r  <= in_data_value;
    end
    if (cmd.emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
      out_done_r <= out_done_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 30'd1;
      len_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_done_res = out_done_r;
  assign out_error    = out_err_r;

endmodule

@@ sv/bech32_string_encoder.sv @@
// Top level of the Bech32 string encoder.
// Each transfer is registered, then decoded, and its result goes to the output register;
// in_stall holds new transfers until the FSM is idle again, also while the output stalls.
// A separator first walks the stored prefix, paced by one memory read per cycle.
// Finish folds six zeros, then emits the six checksum chars as the output takes them.
// Synchronous active-low reset sets the polymod to 1, the prefix length to 0 and the FSM idle.
module bech32_string_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [6:0] in_prefix_char,
  input  logic [7:0] in_data_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_last,
  output logic       out_done_res,
  output logic       out_error
);
  import b32e_pkg::*;

  `include "bech32_string_encoder_assert.svh"

  ctrl_cmd_t cmd;
  ctrl_st_t  st;

  b32e_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  b32e_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_cmd         (in_cmd),
    .in_prefix_char (in_prefix_char),
    .in_data_value  (in_data_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_done_res   (out_done_res),
    .out_error      (out_error)
  );

  `B32E_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)
  `B32E_ASSERT_NOW(a_emit_free, cmd.emit, st.out_free)
  `B32E_ASSERT_NOW(a_no_overflow, cmd.store_en, cmd.start || !st.len_full)
  `B32E_ASSERT_NOW(a_err_final, out_valid && out_error,
                   out_done_res && out_last && (out_char == CHAR_NONE))

endmodule
